>>> hdl/direct_mapped_cache_traffic_model_defines.svh
// Assertion macros shared by the cache traffic model RTL.
`ifndef DIRECT_MAPPED_CACHE_TRAFFIC_MODEL_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_TRAFFIC_MODEL_DEFINES_SVH

// Same-cycle implication, clocked on i_clk and switched off while in reset.
`define DMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and switched off while in reset.
`define DMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dmc_pkg.sv
// Package with the sizes, codes and types of the cache traffic model.
package dmc_pkg;

    // Build-time sizes of the tag store.
    localparam int NUM_LINES  = 128;
    localparam int ADDR_WIDTH = 32;

    // Fixed field widths.
    localparam int ADDR_W  = 32;
    localparam int TAG_W   = 32;
    localparam int CNT_W   = 32;
    localparam int BYTES_W = 40;
    localparam int DL_W    = 8;
    localparam int BL_W    = 4;
    localparam int LL_W    = 3;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int BSIZE_W = 13;
    localparam int SHIFT_W = 12;

    // Derived sizes.
    localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int DT_W  = $clog2(NUM_LINES + 1);

    // Floor of log2 of a positive constant.
    function automatic int floor_log2(input int n);
        int r;
        r = 0;
        for (int k = 1; k < 31; k++) begin
            if ((1 << k) <= n) begin
                r = k;
            end
        end
        return r;
    endfunction

    localparam int LL_CAP = (floor_log2(NUM_LINES) > (2 ** LL_W) - 1) ?
                            (2 ** LL_W) - 1 : floor_log2(NUM_LINES);
    localparam logic [LL_W-1:0] LINES_LOG2_MAX = LL_W'(LL_CAP);
    localparam logic [BL_W-1:0] BLOCK_LOG2_MAX = BL_W'(12);

    // Only the low ADDR_WIDTH bits of an address take part.
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_WIDTH >= ADDR_W) ? {ADDR_W{1'b1}} :
                                              ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
    localparam logic [DL_W-1:0]    DL_MAX    = {DL_W{1'b1}};

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register word indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_WRITE_THROUGH = 2'b00,
        REG_BLOCK_LOG2    = 2'b01,
        REG_LINES_LOG2    = 2'b10
    } t_reg_idx;

    // Configuration as seen by the core.
    typedef struct packed {
        logic            write_through;
        logic [BL_W-1:0] block_log2;
        logic [LL_W-1:0] lines_log2;
    } t_cfg;

endpackage

>>> hdl/dmc_req_if.sv
// Access request channel: valid, ready and one access.
interface dmc_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [dmc_pkg::ADDR_W-1:0] address;

    modport source (output valid, output opcode, output address, input ready);
    modport sink   (input valid, input opcode, input address, output ready);
endinterface

>>> hdl/dmc_rsp_if.sv
// Result channel: valid, ready and the running traffic figures.
interface dmc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [dmc_pkg::CNT_W-1:0]   hit_count;
    logic [dmc_pkg::CNT_W-1:0]   access_count;
    logic [dmc_pkg::BYTES_W-1:0] bytes_mem_to_cache;
    logic [dmc_pkg::BYTES_W-1:0] bytes_cache_to_mem;
    logic [dmc_pkg::DL_W-1:0]    dirty_lines;
    logic [dmc_pkg::BYTES_W-1:0] bytes_cache_to_mem_flushed;

    modport source (output valid, output hit, output hit_count, output access_count,
                    output bytes_mem_to_cache, output bytes_cache_to_mem,
                    output dirty_lines, output bytes_cache_to_mem_flushed, input ready);
    modport sink   (input valid, input hit, input hit_count, input access_count,
                    input bytes_mem_to_cache, input bytes_cache_to_mem,
                    input dirty_lines, input bytes_cache_to_mem_flushed, output ready);
endinterface

>>> hdl/dmc_apb_regs.sv
// APB-style configuration registers of the cache traffic model.
module dmc_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmc_pkg::PADDR_W-1:0] paddr,
    input  logic [dmc_pkg::PDATA_W-1:0] pwdata,
    output logic [dmc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output dmc_pkg::t_cfg               o_cfg
);

    dmc_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    // Register writes; a word beyond the last register is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_through <= 1'b0;
            r_cfg.block_log2    <= dmc_pkg::BL_W'(3);
            r_cfg.lines_log2    <= dmc_pkg::LL_W'(7);
        end else if (wr_en) begin
            unique case (reg_sel)
                dmc_pkg::REG_WRITE_THROUGH: r_cfg.write_through <= pwdata[0];
                dmc_pkg::REG_BLOCK_LOG2:    r_cfg.block_log2    <= pwdata[dmc_pkg::BL_W-1:0];
                dmc_pkg::REG_LINES_LOG2:    r_cfg.lines_log2    <= pwdata[dmc_pkg::LL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            dmc_pkg::REG_WRITE_THROUGH: prdata[0] = r_cfg.write_through;
            dmc_pkg::REG_BLOCK_LOG2:    prdata[dmc_pkg::BL_W-1:0] = r_cfg.block_log2;
            dmc_pkg::REG_LINES_LOG2:    prdata[dmc_pkg::LL_W-1:0] = r_cfg.lines_log2;
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/direct_mapped_cache_traffic_model.sv
// Top level of the direct-mapped cache traffic model.
//
//  Channel   Dir  Handshake              Carries
//  i_req     in   valid/ready            opcode, address
//  o_rsp     out  valid/ready            hit, counters, dirty lines, flushed bytes
//  APB       in   psel/penable/pready    write_through, block_bytes_log2, lines_log2
//
// One access per cycle while the result side is not stalled: the access is registered
// with its tag-RAM read, then the hit check and all counter updates happen in one
// pass into the result register. A tag bypass covers an access to the line that
// the previous access has just filled.
// Reset is synchronous and clears valid bits, dirty bits and counters at once;
// the tag RAM is not cleared. A stalled result holds the pass stage, which in
// turn holds the input once it is full.
`include "direct_mapped_cache_traffic_model_defines.svh"

module direct_mapped_cache_traffic_model (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dmc_req_if.sink                     i_req,
    dmc_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmc_pkg::PADDR_W-1:0] paddr,
    input  logic [dmc_pkg::PDATA_W-1:0] pwdata,
    output logic [dmc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    dmc_pkg::t_cfg cfg;

    dmc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Effective geometry, clamped to what the hardware supports.
    logic [dmc_pkg::BL_W-1:0]    bl_eff;
    logic [dmc_pkg::LL_W-1:0]    ll_eff;
    logic [dmc_pkg::BSIZE_W-1:0] bsize;
    logic [dmc_pkg::IDX_W-1:0]   idx_mask;

    assign bl_eff   = (cfg.block_log2 > dmc_pkg::BLOCK_LOG2_MAX) ?
                      dmc_pkg::BLOCK_LOG2_MAX : cfg.block_log2;
    assign ll_eff   = (cfg.lines_log2 > dmc_pkg::LINES_LOG2_MAX) ?
                      dmc_pkg::LINES_LOG2_MAX : cfg.lines_log2;
    assign bsize    = dmc_pkg::BSIZE_W'(1) << bl_eff;
    assign idx_mask = ~({dmc_pkg::IDX_W{1'b1}} << ll_eff);

    // Handshake control.
    logic r_s1_vld;
    logic r_out_vld;
    logic s1_fire;
    logic in_accept;

    assign s1_fire     = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_s1_vld || s1_fire;
    assign in_accept   = i_req.valid && i_req.ready;

    // Split the incoming address into index and tag.
    logic [dmc_pkg::ADDR_W-1:0] in_addr;
    logic [dmc_pkg::ADDR_W-1:0] in_shifted;
    logic [dmc_pkg::IDX_W-1:0]  in_idx;
    logic [dmc_pkg::TAG_W-1:0]  in_tag;

    assign in_addr    = i_req.address & dmc_pkg::ADDR_MASK;
    assign in_shifted = in_addr >> bl_eff;
    assign in_idx     = in_shifted[dmc_pkg::IDX_W-1:0] & idx_mask;
    assign in_tag     = dmc_pkg::TAG_W'(in_shifted >> ll_eff);

    // Pass stage registers.
    logic                       r_s1_wr;
    logic [dmc_pkg::IDX_W-1:0]  r_s1_idx;
    logic [dmc_pkg::TAG_W-1:0]  r_s1_tag;
    logic [dmc_pkg::TAG_W-1:0]  r_rd_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_wr  <= (i_req.opcode == dmc_pkg::OP_WRITE);
            r_s1_idx <= in_idx;
            r_s1_tag <= in_tag;
        end
    end

    // Tag RAM: one write port from the pass stage, one registered read port.
    logic [dmc_pkg::TAG_W-1:0] r_tag_mem [dmc_pkg::NUM_LINES];
    logic                      s1_hit;

    always_ff @(posedge i_clk) begin
        if (s1_fire && !s1_hit) begin
            r_tag_mem[r_s1_idx] <= r_s1_tag;
        end
        if (in_accept) begin
            r_rd_tag <= r_tag_mem[in_idx];
        end
    end

    // Bypass for a line filled in the cycle its tag was read.
    logic                      r_byp_vld;
    logic [dmc_pkg::IDX_W-1:0] r_byp_idx;
    logic [dmc_pkg::TAG_W-1:0] r_byp_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_vld <= 1'b0;
        end else if (s1_fire && !s1_hit) begin
            r_byp_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && !s1_hit) begin
            r_byp_idx <= r_s1_idx;
            r_byp_tag <= r_s1_tag;
        end
    end

    // Line state bits and running counters.
    logic [dmc_pkg::NUM_LINES-1:0] r_line_valid;
    logic [dmc_pkg::NUM_LINES-1:0] r_line_dirty;
    logic [dmc_pkg::CNT_W-1:0]     r_hits;
    logic [dmc_pkg::CNT_W-1:0]     r_accesses;
    logic [dmc_pkg::BYTES_W-1:0]   r_fetched;
    logic [dmc_pkg::BYTES_W-1:0]   r_stored;
    logic [dmc_pkg::BYTES_W-1:0]   r_flushed;
    logic [dmc_pkg::DT_W-1:0]      r_dirty_total;
    logic                          r_hit;

    // Hit check and policy decisions.
    logic [dmc_pkg::TAG_W-1:0] cur_tag;
    logic                      line_v;
    logic                      line_d;
    logic                      wt;
    logic                      new_d;
    logic                      st_victim;
    logic                      st_write;

    assign cur_tag  = (r_byp_vld && (r_byp_idx == r_s1_idx)) ? r_byp_tag : r_rd_tag;
    assign line_v   = r_line_valid[r_s1_idx];
    assign line_d   = r_line_dirty[r_s1_idx];
    assign wt       = cfg.write_through;
    assign s1_hit   = line_v && (cur_tag == r_s1_tag);
    assign new_d    = s1_hit ? ((r_s1_wr && !wt) || line_d) : (r_s1_wr && !wt);
    assign st_victim = !s1_hit && line_v && line_d;
    assign st_write  = r_s1_wr && wt;

    // Next values of the counters.
    logic [dmc_pkg::CNT_W-1:0]      n_hits;
    logic [dmc_pkg::CNT_W-1:0]      n_accesses;
    logic [dmc_pkg::BYTES_W-1:0]    n_fetched;
    logic [dmc_pkg::BYTES_W-1:0]    n_stored;
    logic [dmc_pkg::BYTES_W-1:0]    n_flushed;
    logic [dmc_pkg::DT_W-1:0]       n_dirty_total;
    logic [dmc_pkg::BSIZE_W:0]      store_add;
    logic [dmc_pkg::BYTES_W:0]      fetch_sum;
    logic [dmc_pkg::BYTES_W:0]      store_sum;
    logic [dmc_pkg::BYTES_W:0]      flush_sum;
    logic [dmc_pkg::DT_W+dmc_pkg::SHIFT_W-1:0] dirty_bytes;

    always_comb begin
        n_hits     = (s1_hit && (r_hits != dmc_pkg::CNT_MAX)) ? r_hits + 1'b1 : r_hits;
        n_accesses = (r_accesses != dmc_pkg::CNT_MAX) ? r_accesses + 1'b1 : r_accesses;

        fetch_sum = {1'b0, r_fetched} + (dmc_pkg::BYTES_W+1)'(bsize);
        if (s1_hit) begin
            n_fetched = r_fetched;
        end else if (fetch_sum > {1'b0, dmc_pkg::BYTES_MAX}) begin
            n_fetched = dmc_pkg::BYTES_MAX;
        end else begin
            n_fetched = fetch_sum[dmc_pkg::BYTES_W-1:0];
        end

        n_dirty_total = r_dirty_total;
        if (!line_d && new_d) begin
            n_dirty_total = r_dirty_total + 1'b1;
        end else if (line_d && !new_d) begin
            n_dirty_total = r_dirty_total - 1'b1;
        end

        store_add = ((dmc_pkg::BSIZE_W+1)'(bsize) & {(dmc_pkg::BSIZE_W+1){st_victim}})
                  + ((dmc_pkg::BSIZE_W+1)'(bsize) & {(dmc_pkg::BSIZE_W+1){st_write}});
        store_sum = {1'b0, r_stored} + (dmc_pkg::BYTES_W+1)'(store_add);
        n_stored  = (store_sum > {1'b0, dmc_pkg::BYTES_MAX}) ?
                    dmc_pkg::BYTES_MAX : store_sum[dmc_pkg::BYTES_W-1:0];

        // The flush total is one three-way add against the old stored count.
        dirty_bytes = (dmc_pkg::DT_W+dmc_pkg::SHIFT_W)'(n_dirty_total) << bl_eff;
        flush_sum   = store_sum + (dmc_pkg::BYTES_W+1)'(dirty_bytes);
        n_flushed   = (flush_sum > {1'b0, dmc_pkg::BYTES_MAX}) ?
                      dmc_pkg::BYTES_MAX : flush_sum[dmc_pkg::BYTES_W-1:0];
    end

    // State update when the pass stage hands its result over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid  <= '0;
            r_line_dirty  <= '0;
            r_hits        <= '0;
            r_accesses    <= '0;
            r_fetched     <= '0;
            r_stored      <= '0;
            r_flushed     <= '0;
            r_dirty_total <= '0;
        end else if (s1_fire) begin
            r_line_valid[r_s1_idx] <= 1'b1;
            r_line_dirty[r_s1_idx] <= new_d;
            r_hits                 <= n_hits;
            r_accesses             <= n_accesses;
            r_fetched              <= n_fetched;
            r_stored               <= n_stored;
            r_flushed              <= n_flushed;
            r_dirty_total          <= n_dirty_total;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_hit <= s1_hit;
        end
    end

    // The counters only move on a hand-over, so they double as the result.
    assign o_rsp.valid                      = r_out_vld;
    assign o_rsp.hit                        = r_hit;
    assign o_rsp.hit_count                  = r_hits;
    assign o_rsp.access_count               = r_accesses;
    assign o_rsp.bytes_mem_to_cache         = r_fetched;
    assign o_rsp.bytes_cache_to_mem         = r_stored;
    assign o_rsp.bytes_cache_to_mem_flushed = r_flushed;
    assign o_rsp.dirty_lines = (r_dirty_total > dmc_pkg::DT_W'(dmc_pkg::DL_MAX)) ?
                               dmc_pkg::DL_MAX : dmc_pkg::DL_W'(r_dirty_total);

    // Checks on the line state and the counters.
    `DMC_ASSERT_NOW(a_hits_within_accesses, r_out_vld, r_hits <= r_accesses, "hits above accesses")
    `DMC_ASSERT_NOW(a_dirty_total_matches, 1'b1, 32'(r_dirty_total) == $countones(r_line_dirty), "dirty count out of step")
    `DMC_ASSERT_NEXT(a_miss_fills_line, s1_fire && !s1_hit, r_line_valid[$past(r_s1_idx)], "missed line not filled")
    `DMC_ASSERT_NEXT(a_hit_fetches_nothing, s1_fire && s1_hit, r_fetched == $past(r_fetched), "fetch on a hit")
    `DMC_ASSERT_NOW(a_flush_not_below_stored, 1'b1, r_flushed >= r_stored, "flush total below stored bytes")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the direct-mapped cache traffic model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index that no register occupies; writes there must be ignored.
    localparam logic [1:0] REG_SPARE = 2'b11;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 125;
    localparam int NUM_PHASES    = 10;
    localparam int HOLD_CYCLES   = 250;
    localparam int BLOCK_LOG2_CAP = 12;

    // One result as it leaves the block.
    typedef struct packed {
        logic                        hit;
        logic [dmc_pkg::CNT_W-1:0]   hit_count;
        logic [dmc_pkg::CNT_W-1:0]   access_count;
        logic [dmc_pkg::BYTES_W-1:0] mem_to_cache;
        logic [dmc_pkg::BYTES_W-1:0] cache_to_mem;
        logic [dmc_pkg::DL_W-1:0]    dirty_lines;
        logic [dmc_pkg::BYTES_W-1:0] flushed;
    } t_traffic_result;

    // Tag store and traffic counters, predicted per access.
    class cache_traffic_scoreboard;
        logic                        write_through;
        logic [dmc_pkg::BL_W-1:0]    block_log2;
        logic [dmc_pkg::LL_W-1:0]    lines_log2;
        logic [dmc_pkg::TAG_W-1:0]   line_tag[dmc_pkg::NUM_LINES];
        bit                          line_valid[dmc_pkg::NUM_LINES];
        bit                          line_dirty[dmc_pkg::NUM_LINES];
        logic [dmc_pkg::CNT_W-1:0]   hits_total;
        logic [dmc_pkg::CNT_W-1:0]   accesses_total;
        logic [dmc_pkg::BYTES_W-1:0] fetched_bytes;
        logic [dmc_pkg::BYTES_W-1:0] stored_bytes;
        int unsigned                 dirty_total;
        t_traffic_result             expected_results[$];
        int                          failures;

        function new();
            write_through  = 1'b0;
            block_log2     = 4'd3;
            lines_log2     = 3'd7;
            hits_total     = '0;
            accesses_total = '0;
            fetched_bytes  = '0;
            stored_bytes   = '0;
            dirty_total    = 0;
            failures       = 0;
            for (int k = 0; k < dmc_pkg::NUM_LINES; k++) begin
                line_tag[k]   = '0;
                line_valid[k] = 1'b0;
                line_dirty[k] = 1'b0;
            end
        endfunction

        function logic [dmc_pkg::BYTES_W-1:0] add_bytes(logic [dmc_pkg::BYTES_W-1:0] a,
                                                        logic [dmc_pkg::BYTES_W-1:0] b);
            logic [dmc_pkg::BYTES_W:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[dmc_pkg::BYTES_W] ? dmc_pkg::BYTES_MAX : sum[dmc_pkg::BYTES_W-1:0];
        endfunction

        function logic [dmc_pkg::CNT_W-1:0] bump_count(logic [dmc_pkg::CNT_W-1:0] a);
            return (a == dmc_pkg::CNT_MAX) ? a : a + 1'b1;
        endfunction

        function void set_register(logic [1:0] idx, logic [dmc_pkg::PDATA_W-1:0] value);
            case (idx)
                dmc_pkg::REG_WRITE_THROUGH: write_through = value[0];
                dmc_pkg::REG_BLOCK_LOG2:    block_log2    = value[dmc_pkg::BL_W-1:0];
                dmc_pkg::REG_LINES_LOG2:    lines_log2    = value[dmc_pkg::LL_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Works out the result of one accepted access and queues it.
        function void note_access(logic op, logic [dmc_pkg::ADDR_W-1:0] address);
            int unsigned                 blk;
            int unsigned                 lin;
            int unsigned                 idx;
            logic [dmc_pkg::BYTES_W-1:0] bsize;
            logic [dmc_pkg::ADDR_W-1:0]  addr;
            logic [dmc_pkg::TAG_W-1:0]   tag;
            bit                          hit;
            bit                          is_write;
            bit                          new_dirty;
            t_traffic_result             r;
            blk = (block_log2 > BLOCK_LOG2_CAP) ? BLOCK_LOG2_CAP : block_log2;
            lin = lines_log2;
            while (lin > 0 && (1 << lin) > dmc_pkg::NUM_LINES) begin
                lin--;
            end
            bsize    = dmc_pkg::BYTES_W'(1) << blk;
            is_write = (op == dmc_pkg::OP_WRITE);
            addr     = address & dmc_pkg::ADDR_MASK;
            idx      = (addr >> blk) & ((1 << lin) - 1);
            tag      = addr >> (blk + lin);
            hit      = line_valid[idx] && (line_tag[idx] == tag);

            accesses_total = bump_count(accesses_total);
            if (hit) begin
                hits_total = bump_count(hits_total);
                if (is_write) begin
                    if (write_through) begin
                        stored_bytes = add_bytes(stored_bytes, bsize);
                    end else if (!line_dirty[idx]) begin
                        line_dirty[idx] = 1'b1;
                        dirty_total++;
                    end
                end
            end else begin
                // A dirty victim is written back before the fill.
                if (line_valid[idx] && line_dirty[idx]) begin
                    stored_bytes = add_bytes(stored_bytes, bsize);
                end
                fetched_bytes = add_bytes(fetched_bytes, bsize);
                if (is_write && write_through) begin
                    stored_bytes = add_bytes(stored_bytes, bsize);
                end
                new_dirty = is_write && !write_through;
                if (line_dirty[idx] && !new_dirty) begin
                    dirty_total--;
                end else if (!line_dirty[idx] && new_dirty) begin
                    dirty_total++;
                end
                line_dirty[idx] = new_dirty;
                line_tag[idx]   = tag;
                line_valid[idx] = 1'b1;
            end

            r.hit          = hit;
            r.hit_count    = hits_total;
            r.access_count = accesses_total;
            r.mem_to_cache = fetched_bytes;
            r.cache_to_mem = stored_bytes;
            r.dirty_lines  = (dirty_total > 255) ? dmc_pkg::DL_MAX :
                                                   dmc_pkg::DL_W'(dirty_total);
            r.flushed      = add_bytes(stored_bytes,
                                       dmc_pkg::BYTES_W'(dirty_total) * bsize);
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [dmc_pkg::BYTES_W-1:0] want,
                                    logic [dmc_pkg::BYTES_W-1:0] got);
            if (got !== want) begin
                if (failures < MAX_REPORTS) begin
                    $display("MISMATCH %s: expected 0x%0h, got 0x%0h", name, want, got);
                end
                failures++;
            end
        endfunction

        // Compares one accepted result against the oldest expectation.
        function void check_result(t_traffic_result got);
            t_traffic_result want;
            if (expected_results.size() == 0) begin
                if (failures < MAX_REPORTS) begin
                    $display("UNEXPECTED result: hit %0b, access_count %0d",
                             got.hit, got.access_count);
                end
                failures++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("hit",                        want.hit,          got.hit);
            compare_field("hit_count",                  want.hit_count,    got.hit_count);
            compare_field("access_count",               want.access_count, got.access_count);
            compare_field("bytes_mem_to_cache",         want.mem_to_cache, got.mem_to_cache);
            compare_field("bytes_cache_to_mem",         want.cache_to_mem, got.cache_to_mem);
            compare_field("dirty_lines",                want.dirty_lines,  got.dirty_lines);
            compare_field("bytes_cache_to_mem_flushed", want.flushed,      got.flushed);
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [dmc_pkg::PADDR_W-1:0]  paddr;
    logic [dmc_pkg::PDATA_W-1:0]  pwdata;
    logic [dmc_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    dmc_req_if access_if ();
    dmc_rsp_if result_if ();

    direct_mapped_cache_traffic_model i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (access_if),
        .o_rsp   (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cache_traffic_scoreboard traffic_sb = new();

    int          burst_left   = 0;
    int unsigned geom_blk     = 3;
    int unsigned geom_lin     = 7;
    int          results_seen = 0;
    int          cycle_count  = 0;

    // Phase plan for the random part; the last two phases are drawn at random.
    bit          plan_wt[NUM_PHASES] = '{0, 1, 0, 1, 0, 0, 1, 0, 0, 0};
    int unsigned plan_bl[NUM_PHASES] = '{0, 12, 13, 0, 3, 12, 4, 15, 0, 0};
    int unsigned plan_ll[NUM_PHASES] = '{0, 7, 3, 7, 7, 0, 5, 7, 0, 0};

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit, in case the block stops answering.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Result side: checks each transfer and stalls on a pattern of its own,
    // with two long hold-offs so that the block backs up into its input.
    initial begin
        int rcv_cycle;
        int hold_left;
        int next_hold_at;
        int holds_done;
        t_traffic_result got;
        rcv_cycle    = 0;
        hold_left    = 0;
        next_hold_at = 300;
        holds_done   = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready) begin
                got.hit          = result_if.hit;
                got.hit_count    = result_if.hit_count;
                got.access_count = result_if.access_count;
                got.mem_to_cache = result_if.bytes_mem_to_cache;
                got.cache_to_mem = result_if.bytes_cache_to_mem;
                got.dirty_lines  = result_if.dirty_lines;
                got.flushed      = result_if.bytes_cache_to_mem_flushed;
                traffic_sb.check_result(got);
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (holds_done < 2 && results_seen >= next_hold_at) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
                next_hold_at += 500;
                result_if.ready <= 1'b0;
            end else begin
                case ((rcv_cycle / 97) % 4)
                    0: result_if.ready <= 1'b1;
                    1: result_if.ready <= 1'($urandom_range(0, 1));
                    2: result_if.ready <= (rcv_cycle % 4 == 0);
                    default: result_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
            rcv_cycle++;
        end
    end

    // Offers one access in bursts with random gaps and returns at its transfer.
    task automatic send_access(logic op, logic [dmc_pkg::ADDR_W-1:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                access_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
        end
        burst_left--;
        access_if.valid   <= 1'b1;
        access_if.opcode  <= op;
        access_if.address <= addr;
        do begin
            @(posedge i_clk);
        end while (!access_if.ready);
        traffic_sb.note_access(op, addr);
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic drain();
        access_if.valid <= 1'b0;
        burst_left = 0;
        do begin
            @(posedge i_clk);
        end while (traffic_sb.pending() != 0);
    endtask

    // APB write: a setup phase, an access phase that waits for pready, then an idle phase.
    task automatic write_register(logic [1:0] idx, logic [dmc_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dmc_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        traffic_sb.set_register(idx, value);
        @(posedge i_clk);
    endtask

    // Sets all three registers, with junk in the unused upper bits.
    task automatic configure(bit wt, int unsigned bl, int unsigned ll);
        write_register(dmc_pkg::REG_WRITE_THROUGH, ($urandom & ~32'h1) | dmc_pkg::PDATA_W'(wt));
        write_register(dmc_pkg::REG_BLOCK_LOG2, ($urandom & ~32'hF) | dmc_pkg::PDATA_W'(bl));
        write_register(dmc_pkg::REG_LINES_LOG2, ($urandom & ~32'h7) | dmc_pkg::PDATA_W'(ll));
        geom_blk = (bl > BLOCK_LOG2_CAP) ? BLOCK_LOG2_CAP : bl;
        geom_lin = ll;
    endtask

    // Mostly a hot working set, with conflict misses and some wild addresses.
    task automatic run_random_phase(int count);
        logic [dmc_pkg::ADDR_W-1:0] hot[8];
        logic [dmc_pkg::ADDR_W-1:0] addr;
        logic [dmc_pkg::ADDR_W-1:0] offset_mask;
        int                         pick;
        int                         slot;
        offset_mask = (dmc_pkg::ADDR_W'(1) << geom_blk) - 1'b1;
        for (int k = 0; k < 8; k++) begin
            hot[k] = $urandom;
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, 7);
            if (pick < 60) begin
                addr = (hot[slot] & ~offset_mask) | ($urandom & offset_mask);
            end else if (pick < 80) begin
                addr = hot[slot] ^ (dmc_pkg::ADDR_W'($urandom_range(1, 3))
                                    << (geom_blk + geom_lin));
                hot[slot] = addr;
            end else begin
                addr = $urandom;
            end
            send_access(1'($urandom_range(0, 1)), addr);
        end
        drain();
    endtask

    // Main sequence: reset, directed accesses, random phases, verdict.
    initial begin
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        access_if.valid   <= 1'b0;
        access_if.opcode  <= dmc_pkg::OP_READ;
        access_if.address <= '0;
        i_rst_n           <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry, write-back: fill, hits, dirtying and evictions.
        send_access(dmc_pkg::OP_READ,  32'h0000_0000);
        send_access(dmc_pkg::OP_READ,  32'h0000_0004);
        send_access(dmc_pkg::OP_WRITE, 32'h0000_0000);
        send_access(dmc_pkg::OP_WRITE, 32'h0000_0000);
        send_access(dmc_pkg::OP_READ,  32'h0000_0400);
        send_access(dmc_pkg::OP_WRITE, 32'hFFFF_FFFF);
        send_access(dmc_pkg::OP_READ,  32'hFFFF_FFF8);
        send_access(dmc_pkg::OP_WRITE, 32'h8000_03F8);
        send_access(dmc_pkg::OP_WRITE, 32'h1234_5678);
        send_access(dmc_pkg::OP_READ,  32'h1234_5678);
        drain();

        // Oversized block and a single line under write-through; the dirty
        // lines left from the old geometry still count towards the flush.
        configure(1'b1, 15, 0);
        write_register(REG_SPARE, 32'hFFFF_FFFF);
        send_access(dmc_pkg::OP_WRITE, 32'h0000_0000);
        send_access(dmc_pkg::OP_WRITE, 32'h0000_0FFF);
        send_access(dmc_pkg::OP_READ,  32'h0000_1000);
        drain();

        // Back to the reset geometry, still write-through: hits on dirty lines
        // leave them dirty until they are evicted.
        configure(1'b1, 3, 7);
        send_access(dmc_pkg::OP_WRITE, 32'h8000_03F8);
        send_access(dmc_pkg::OP_READ,  32'hFFFF_FFF8);
        send_access(dmc_pkg::OP_WRITE, 32'h1234_5678);
        send_access(dmc_pkg::OP_READ,  32'h1234_5678);
        drain();

        // Random phases over a range of settings, extremes included.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p >= 8) begin
                plan_wt[p] = 1'($urandom_range(0, 1));
                plan_bl[p] = $urandom_range(0, 15);
                plan_ll[p] = $urandom_range(0, 7);
            end
            configure(plan_wt[p], plan_bl[p], plan_ll[p]);
            run_random_phase(PHASE_ITEMS);
        end

        repeat (8) @(posedge i_clk);
        if (traffic_sb.failures == 0 && traffic_sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
